/* sv/assert_macros.svh */
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("next-cycle check failed");

// Check a condition in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("same-cycle check failed");

`endif

/* sv/ocd_pkg.sv */
// Package: constants and types of the cell deframer.
`default_nettype none

package ocd_pkg;

  localparam int CountW   = 17;
  localparam int CircW    = 3;
  localparam int FixedW   = 13;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  // Command codes
  localparam logic [7:0] CMD_VERSIONS = 8'd7;
  localparam logic [7:0] CMD_VPADDING = 8'd128;

  // Register limits and reset values
  localparam logic [CircW-1:0]  CIRC_MIN    = 3'd2;
  localparam logic [CircW-1:0]  CIRC_MAX    = 3'd4;
  localparam logic [CircW-1:0]  CIRC_RESET  = 3'd4;
  localparam logic [FixedW-1:0] FIXED_MIN   = 13'd8;
  localparam logic [FixedW-1:0] FIXED_MAX   = 13'd4096;
  localparam logic [FixedW-1:0] FIXED_RESET = 13'd514;

  // Register index (address bit 2)
  localparam logic REG_CIRC_ID = 1'b0;
  localparam logic REG_FIXED   = 1'b1;

  // Header bytes after the circuit id: command plus two length bytes
  localparam logic [CountW-1:0] VAR_HDR_EXTRA = 17'd3;

  typedef struct packed {
    logic [CircW-1:0]  circ_id_bytes;
    logic [FixedW-1:0] fixed_cell_bytes;
  } cfg_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       variable;
    logic [7:0] command;
  } tag_t;

endpackage

`default_nettype wire

/* sv/ocd_cell_tracker.sv */
// Cell position tracker: tags each byte with its place in the current cell.
`default_nettype none
`include "assert_macros.svh"

module ocd_cell_tracker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  input  wire ocd_pkg::cfg_t cfg,
  output ocd_pkg::tag_t      tag
);

  localparam int CW = ocd_pkg::CountW;

  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    cell_command, cell_command_next;
  logic          variable_flag, variable_flag_next;
  logic [CW-1:0] end_position, end_position_next;
  logic [7:0]    length_high, length_high_next;

  logic [ocd_pkg::CircW-1:0]  circ_eff;
  logic [ocd_pkg::FixedW-1:0] fixed_eff;
  logic [CW-1:0] circ_pos, len_hi_pos, len_lo_pos, pos_inc;
  logic          is_cmd_pos, past_id, cmd_var, known, last;

  // Clamp the configuration into range
  always_comb begin
    if (cfg.circ_id_bytes < ocd_pkg::CIRC_MIN) begin
      circ_eff = ocd_pkg::CIRC_MIN;
    end else if (cfg.circ_id_bytes > ocd_pkg::CIRC_MAX) begin
      circ_eff = ocd_pkg::CIRC_MAX;
    end else begin
      circ_eff = cfg.circ_id_bytes;
    end
    if (cfg.fixed_cell_bytes < ocd_pkg::FIXED_MIN) begin
      fixed_eff = ocd_pkg::FIXED_MIN;
    end else if (cfg.fixed_cell_bytes > ocd_pkg::FIXED_MAX) begin
      fixed_eff = ocd_pkg::FIXED_MAX;
    end else begin
      fixed_eff = cfg.fixed_cell_bytes;
    end
  end

  // Decode the byte position
  assign circ_pos   = {{(CW-ocd_pkg::CircW){1'b0}}, circ_eff};
  assign len_hi_pos = circ_pos + CW'(1);
  assign len_lo_pos = circ_pos + CW'(2);
  assign pos_inc    = byte_count + CW'(1);
  assign is_cmd_pos = (byte_count == circ_pos);
  assign past_id    = (byte_count >= circ_pos);
  assign cmd_var    = (rx_byte == ocd_pkg::CMD_VERSIONS) || (rx_byte >= ocd_pkg::CMD_VPADDING);

  // Update the cell header fields and find the end of the cell
  always_comb begin
    cell_command_next  = cell_command;
    variable_flag_next = variable_flag;
    end_position_next  = end_position;
    length_high_next   = length_high;
    if (is_cmd_pos) begin
      cell_command_next  = rx_byte;
      variable_flag_next = cmd_var;
      if (!cmd_var) begin
        end_position_next = {{(CW-ocd_pkg::FixedW){1'b0}}, fixed_eff};
      end
    end else if (past_id && variable_flag && byte_count == len_hi_pos) begin
      length_high_next = rx_byte;
    end else if (past_id && variable_flag && byte_count == len_lo_pos) begin
      end_position_next = circ_pos + ocd_pkg::VAR_HDR_EXTRA
                          + {{(CW-16){1'b0}}, length_high, rx_byte};
    end

    if (!past_id) begin
      known = 1'b0;
    end else if (variable_flag_next) begin
      known = (byte_count >= len_lo_pos);
    end else begin
      known = 1'b1;
    end
    last = known && (pos_inc == end_position_next);
    byte_count_next = last ? '0 : pos_inc;
  end

  // Tags for the current byte
  assign tag.first    = (byte_count == '0);
  assign tag.last     = last;
  assign tag.variable = past_id ? variable_flag_next : 1'b0;
  assign tag.command  = past_id ? cell_command_next : 8'd0;

  // Advance framing state on each accepted byte; restart on a register write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_count    <= '0;
      cell_command  <= '0;
      variable_flag <= 1'b0;
      end_position  <= '0;
      length_high   <= '0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      cell_command  <= cell_command_next;
      variable_flag <= variable_flag_next;
      end_position  <= end_position_next;
      length_high   <= length_high_next;
    end
  end

  `ASSERT_NEXT(a_restart_after_last, clk, rst, accept && last && !clear, byte_count == '0)
  `ASSERT_NEXT(a_count_advances, clk, rst, accept && !last && !clear,
               byte_count == $past(byte_count) + CW'(1))
  `ASSERT_SAME(a_no_last_in_circ_id, clk, rst, !past_id, !last)

endmodule

`default_nettype wire

/* sv/onion_cell_deframer.sv */
// Top level of the link cell deframer: register port, byte channel, result register.
`default_nettype none

// Usage:
//   Bytes of the link stream enter on rx_valid/rx_byte; a word is taken at a
//   clock edge with rx_valid high and rx_stall low. Each byte leaves in the next
//   cycle on out_valid with data_byte and its tags: cell_first, cell_last,
//   is_variable and command_seen. The receiver holds out_stall to pause.
//   Throughput is one byte per cycle while out_stall is low: the per-byte
//   decision is a position compare against the cell end in the tracker, and
//   the result register allows a new byte while the last one is taken.
//   While a result waits under out_stall, rx_stall is raised and the held
//   result does not change.
//   The APB port sets the circuit id width (address 0) and fixed cell length
//   (address 4); pready is always high. A write restarts framing so the next
//   byte begins a new cell; write only while the stream is idle.
//   Synchronous reset (rst) empties the result register, restarts framing and
//   returns the registers to 4-byte circuit ids and 514-byte fixed cells.

module onion_cell_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ocd_pkg::AddrW-1:0]     paddr,
  input  wire logic [ocd_pkg::DataW-1:0]     pwdata,
  output      logic [ocd_pkg::DataW-1:0]     prdata,
  output      logic                          pready,
  input  wire logic                          rx_valid,
  output      logic                          rx_stall,
  input  wire logic [7:0]                    rx_byte,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [7:0]                    data_byte,
  output      logic                          cell_first,
  output      logic                          cell_last,
  output      logic                          is_variable,
  output      logic [7:0]                    command_seen
);

  ocd_pkg::cfg_t cfg;
  ocd_pkg::tag_t tag;
  logic          cfg_write, accept;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circ_id_bytes    <= ocd_pkg::CIRC_RESET;
      cfg.fixed_cell_bytes <= ocd_pkg::FIXED_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        ocd_pkg::REG_CIRC_ID: cfg.circ_id_bytes    <= pwdata[ocd_pkg::CircW-1:0];
        ocd_pkg::REG_FIXED:   cfg.fixed_cell_bytes <= pwdata[ocd_pkg::FixedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ocd_pkg::REG_CIRC_ID:
        prdata = {{(ocd_pkg::DataW-ocd_pkg::CircW){1'b0}}, cfg.circ_id_bytes};
      ocd_pkg::REG_FIXED:
        prdata = {{(ocd_pkg::DataW-ocd_pkg::FixedW){1'b0}}, cfg.fixed_cell_bytes};
      default:
        prdata = '0;
    endcase
  end

  // Take a byte whenever the result register is free or being emptied
  assign rx_stall = out_valid && out_stall;
  assign accept   = rx_valid && !rx_stall;

  ocd_cell_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_write),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .tag     (tag)
  );

  // Result register: load on accept, drop when taken, hold under stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte    <= rx_byte;
      cell_first   <= tag.first;
      cell_last    <= tag.last;
      is_variable  <= tag.variable;
      command_seen <= tag.command;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the link cell deframer: cell framing of random byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ocd_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned FLOOD_HOLD = 350;

  typedef struct packed {
    logic [7:0] data;
    tag_t       tag;
  } cell_word_t;

  logic clk;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic       cell_first;
  logic       cell_last;
  logic       is_variable;
  logic [7:0] command_seen;

  onion_cell_deframer uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .cell_first  (cell_first),
    .cell_last   (cell_last),
    .is_variable (is_variable),
    .command_seen(command_seen)
  );

  // Framing tracker of the bench, with its own copy of the registers
  logic [CircW-1:0]  cfg_circ = CIRC_RESET;
  logic [FixedW-1:0] cfg_fixed = FIXED_RESET;
  logic [CountW-1:0] cell_pos = '0;
  logic [7:0]        cell_cmd = '0;
  logic              cell_var = 1'b0;
  logic [CountW-1:0] cell_end = '0;
  logic [7:0]        len_hi = '0;

  logic [7:0]  link_bytes[$];
  cell_word_t  due_words[$];
  int unsigned fed_total = 0;
  int unsigned errors = 0;
  int unsigned stuck = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;
  bit          flood_hold = 1'b0;
  bit          rx_took = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CircW-1:0] circ_eff();
    if (cfg_circ < CIRC_MIN) return CIRC_MIN;
    if (cfg_circ > CIRC_MAX) return CIRC_MAX;
    return cfg_circ;
  endfunction

  function automatic logic [FixedW-1:0] fixed_eff();
    if (cfg_fixed < FIXED_MIN) return FIXED_MIN;
    if (cfg_fixed > FIXED_MAX) return FIXED_MAX;
    return cfg_fixed;
  endfunction

  function automatic logic opens_var_cell(input logic [7:0] cmd);
    return (cmd == CMD_VERSIONS) || (cmd >= CMD_VPADDING);
  endfunction

  // Mostly no pause, some short ones, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tag one accepted byte and queue the word the block must return for it
  task automatic frame_byte(input logic [7:0] b);
    logic [CountW-1:0] circ;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] nxt;
    logic              past_id;
    logic              known;
    logic              last;
    cell_word_t        w;
    circ = CountW'(circ_eff());
    pos = cell_pos;
    past_id = (pos >= circ);
    if (pos == circ) begin
      cell_cmd = b;
      cell_var = opens_var_cell(b);
      if (!cell_var) cell_end = CountW'(fixed_eff());
    end else if (past_id && cell_var && pos == circ + 1) begin
      len_hi = b;
    end else if (past_id && cell_var && pos == circ + 2) begin
      cell_end = circ + VAR_HDR_EXTRA + {len_hi, b};
    end
    known = past_id && (!cell_var || pos >= circ + 2);
    nxt = pos + 1'b1;
    last = known && (nxt == cell_end);
    w.data = b;
    w.tag.first = (pos == '0);
    w.tag.last = last;
    w.tag.variable = past_id & cell_var;
    w.tag.command = past_id ? cell_cmd : 8'h00;
    due_words.push_back(w);
    cell_pos = last ? '0 : nxt;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Queue one cell at the current settings; keep limits how many bytes go out
  task automatic queue_cell(input logic [7:0] cmd, input logic [15:0] vlen,
                            input int unsigned keep);
    logic [7:0]  cell_bytes[$];
    int unsigned body;
    cell_bytes = {};
    repeat (circ_eff()) cell_bytes.push_back(8'($urandom_range(0, 255)));
    cell_bytes.push_back(cmd);
    if (opens_var_cell(cmd)) begin
      cell_bytes.push_back(vlen[15:8]);
      cell_bytes.push_back(vlen[7:0]);
      body = 32'(vlen);
    end else begin
      body = fixed_eff() - circ_eff() - 1;
    end
    repeat (body) cell_bytes.push_back(8'($urandom_range(0, 255)));
    for (int unsigned k = 0; k < cell_bytes.size() && (keep == 0 || k < keep); k++) begin
      link_bytes.push_back(cell_bytes[k]);
      fed_total++;
    end
  endtask

  // Well-formed cells with random content, optionally a ragged tail of loose bytes
  task automatic random_cells(input int unsigned budget, input int unsigned fixed_pct,
                              input bit ragged);
    int unsigned start;
    logic [7:0]  cmd;
    logic [15:0] vlen;
    start = fed_total;
    while (fed_total - start < budget) begin
      if ($urandom_range(0, 99) < fixed_pct) begin
        cmd = 8'($urandom_range(0, 127));
        if (cmd == CMD_VERSIONS) cmd = 8'd8;
      end else if ($urandom_range(0, 4) == 0) begin
        cmd = CMD_VERSIONS;
      end else begin
        cmd = 8'($urandom_range(128, 255));
      end
      vlen = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(0, 24))
                                        : 16'($urandom_range(25, 300));
      queue_cell(cmd, vlen, 0);
    end
    if (ragged) repeat ($urandom_range(1, 6)) link_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Wait until every queued byte has gone through and come back
  task automatic drain();
    while (link_bytes.size() != 0 || rx_valid || due_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [DataW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // the write lands at this edge and restarts framing
    if (idx == REG_CIRC_ID) cfg_circ = value[CircW-1:0];
    else cfg_fixed = value[FixedW-1:0];
    cell_pos = '0;
    cell_cmd = '0;
    cell_var = 1'b0;
    cell_end = '0;
    len_hi = '0;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read_check(input logic idx, input logic [FixedW-1:0] want);
    logic ok;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CIRC_ID) ok = (prdata[CircW-1:0] == want[CircW-1:0]);
    else ok = (prdata[FixedW-1:0] == want);
    if (!ok) begin
      errors++;
      $display("%0t: register %0d read mismatch, expected %0h, got %0h",
               $time, idx, want, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_regs(input logic [CircW-1:0] circ, input logic [FixedW-1:0] fixed);
    drain();
    reg_write(REG_CIRC_ID, DataW'(circ));
    reg_write(REG_FIXED, DataW'(fixed));
    reg_read_check(REG_CIRC_ID, FixedW'(circ));
    reg_read_check(REG_FIXED, fixed);
  endtask

  // Sender: advance to the next byte once the current word is taken
  always @(negedge clk) begin
    if (!rx_valid || rx_took) begin
      rx_took = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        rx_valid <= 1'b0;
      end else if (link_bytes.size() != 0) begin
        rx_valid <= 1'b1;
        rx_byte <= link_bytes.pop_front();
        gap_left = idle_len();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin : receiver
    int unsigned n;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (flood_hold) begin
      flood_hold = 1'b0;
      hold_left = FLOOD_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      n = idle_len();
      if (n != 0) begin
        hold_left = n - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted byte, check every accepted word
  always @(posedge clk) begin : monitor
    cell_word_t want;
    bit         moved;
    moved = 1'b0;
    if (!rst) begin
      if (rx_valid && !rx_stall) begin
        frame_byte(rx_byte);
        rx_took = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got data %0h", $time, data_byte);
        end else begin
          want = due_words.pop_front();
          check_field("data_byte", want.data, data_byte);
          check_field("cell_first", 8'(want.tag.first), 8'(cell_first));
          check_field("cell_last", 8'(want.tag.last), 8'(cell_last));
          check_field("is_variable", 8'(want.tag.variable), 8'(is_variable));
          check_field("command_seen", want.tag.command, command_seen);
        end
      end
      // drop the run if nothing moves for too long
      if (moved) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck == STUCK_LIMIT) begin
          $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
          $display("** onion_cell_deframer: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reg_read_check(REG_CIRC_ID, FixedW'(CIRC_RESET));
    reg_read_check(REG_FIXED, FIXED_RESET);

    // Reset settings: empty VERSIONS cell, one-byte VPADDING-range cell,
    // then a cell announcing the largest length, cut short by the next write
    queue_cell(CMD_VERSIONS, 16'd0, 0);
    queue_cell(8'hFF, 16'd1, 0);
    queue_cell(8'd200, 16'hFFFF, 9);

    // Narrow ids, shortest fixed cells; last fixed command and first VPADDING
    program_regs(3'd2, 13'd8);
    idle_on = 1'b0;
    queue_cell(8'd127, 16'd0, 0);
    queue_cell(CMD_VPADDING, 16'd0, 0);
    random_cells(30, 40, 1'b0);

    // Out-of-range settings below the limits
    program_regs(3'd0, 13'd0);
    idle_on = 1'b1;
    random_cells(30, 40, 1'b1);

    // Fill the block behind a long receiver hold
    program_regs(3'd3, 13'd20);
    random_cells(60, 40, 1'b0);
    flood_hold = 1'b1;

    program_regs(3'd1, 13'd7);
    random_cells(30, 50, 1'b1);

    program_regs(3'd5, 13'd9);
    random_cells(30, 40, 1'b0);

    program_regs(3'd7, 13'd33);
    random_cells(30, 30, 1'b1);

    // Largest fixed size: variable cells, then a fixed cell cut short
    program_regs(3'd4, 13'd4096);
    random_cells(30, 0, 1'b0);
    queue_cell(8'd1, 16'd0, 30);

    // Fixed size above the limit: a fixed cell cut short, then a long
    // variable cell whose length needs the high length byte
    program_regs(3'd2, 13'h1FFF);
    queue_cell(8'd0, 16'd0, 40);
    program_regs(3'd2, 13'h1FFF);
    queue_cell(CMD_VERSIONS, 16'd256, 0);
    random_cells(30, 0, 1'b0);

    drain();
    if (errors == 0) $display("** onion_cell_deframer: PASSED **");
    else $display("** onion_cell_deframer: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/ocd_pkg.sv
sv/ocd_cell_tracker.sv
sv/onion_cell_deframer.sv
bench/tb_top.sv
